### sv/pscg_pkg.sv
// Shared types, constants and status codes for the per-channel sequence gap checker.
// No dependencies; imported by pscg_calc and per_channel_sequence_gap_checker.

package pscg_pkg;

    // Number of tracked origin channels (1 to 256).
    localparam int CHANNELS = 4;
    // Entry index width; one bit minimum so a single-entry store still has an address.
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Payload validity constants.
    localparam logic [23:0] MARKER_VALID = 24'hAA555A;
    localparam logic [3:0]  MIN_DLC      = 4'd8;
    localparam logic [8:0]  CHANNELS_9B  = 9'(CHANNELS);

    // Result status codes.
    typedef logic [2:0] t_status;
    localparam t_status ST_FIRST   = 3'd0;
    localparam t_status ST_INORDER = 3'd1;
    localparam t_status ST_GAP     = 3'd2;
    localparam t_status ST_REORDER = 3'd3;
    localparam t_status ST_INVALID = 3'd4;

    // One row of the per-origin state memory.
    typedef struct packed {
        logic [31:0] expected;
        logic [31:0] missing;
        logic [31:0] reorder;
    } t_row;

    // Frame fields held in the lookup stage.
    typedef struct packed {
        logic [7:0]  phys_channel;
        logic [3:0]  dlc;
        logic [7:0]  src_channel;
        logic [31:0] seq_number;
        logic [23:0] marker_bytes;
    } t_frame;

    // Classification result handed back to the pipeline.
    typedef struct packed {
        t_status     status;
        logic        payload_ok;
        logic [31:0] gap_size;
        t_row        row_new;
        logic [31:0] missing_total;
        logic [31:0] reorder_total;
    } t_calc;

endpackage

### sv/pscg_calc.sv
// Frame classification and per-origin state update for one frame.
// Depends on pscg_pkg; instantiated by per_channel_sequence_gap_checker.

module pscg_calc
    import pscg_pkg::*;
(
    input  t_frame i_frame,
    input  t_row   i_row,
    input  logic   i_seen,
    output t_calc  o_calc
);

    logic        payload_ok;
    t_row        row_eff;
    logic [31:0] gap_fwd;

    // Payload check: long enough, markers intact, origin tracked
    assign payload_ok = (i_frame.dlc >= MIN_DLC)
                     && (i_frame.marker_bytes == MARKER_VALID)
                     && ({1'b0, i_frame.src_channel} < CHANNELS_9B);

    // An entry never written reads as zero
    assign row_eff = i_seen ? i_row : '0;
    assign gap_fwd = i_frame.seq_number - row_eff.expected;

    // Sequence classification
    always_comb begin
        o_calc            = '0;
        o_calc.payload_ok = payload_ok;
        o_calc.row_new    = row_eff;
        if (!payload_ok) begin
            o_calc.status = ST_INVALID;
        end else begin
            if (!i_seen) begin
                o_calc.status           = ST_FIRST;
                o_calc.gap_size         = i_frame.seq_number;
                o_calc.row_new.missing  = row_eff.missing + i_frame.seq_number;
                o_calc.row_new.expected = i_frame.seq_number + 32'd1;
            end else if (i_frame.seq_number == row_eff.expected) begin
                o_calc.status           = ST_INORDER;
                o_calc.row_new.expected = row_eff.expected + 32'd1;
            end else if (i_frame.seq_number > row_eff.expected) begin
                o_calc.status           = ST_GAP;
                o_calc.gap_size         = gap_fwd;
                o_calc.row_new.missing  = row_eff.missing + gap_fwd;
                o_calc.row_new.expected = i_frame.seq_number + 32'd1;
            end else begin
                o_calc.status          = ST_REORDER;
                o_calc.row_new.reorder = row_eff.reorder + 32'd1;
            end
            o_calc.missing_total = o_calc.row_new.missing;
            o_calc.reorder_total = o_calc.row_new.reorder;
        end
    end

endmodule

### sv/per_channel_sequence_gap_checker.sv
// Top level of the per-channel sequence gap checker: state memory, pipeline, output register.
// Depends on pscg_pkg and pscg_calc.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------------------
//   in      | input     | i_in_valid/o_in_stall   | phys_channel, dlc, src_channel, seq, markers
//   out     | output    | o_out_valid/i_out_stall | status, phys_bad, gap, missing/reorder/invalid
//
// One frame per cycle while the output is not stalled. The per-origin row is read
// from the state memory into the lookup stage, then classified and written back,
// and the result sits in the output register. A write made in the same cycle
// as the next frame's read is forwarded. Seen flags are flip-flops cleared by
// reset, so no clearing pass is needed. A stall while the output register holds
// a result freezes the whole pipeline and is passed to the input in the same cycle.

module per_channel_sequence_gap_checker
    import pscg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_phys_channel,
    input  logic [3:0]  i_dlc,
    input  logic [7:0]  i_src_channel,
    input  logic [31:0] i_seq_number,
    input  logic [23:0] i_marker_bytes,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic        o_phys_bad,
    output logic [31:0] o_gap_size,
    output logic [31:0] o_missing_total,
    output logic [31:0] o_reorder_total,
    output logic [31:0] o_invalid_total
);

    // State memory and read port
    t_row              mem [CHANNELS];
    t_row              r_rd_row;

    // Lookup stage
    logic              r_s1_vld;
    t_frame            r_s1_frame;
    logic [CH_W-1:0]   s1_idx;

    // Forwarding of the write made alongside the lookup stage's read
    logic              r_wb_vld;
    logic [CH_W-1:0]   r_wb_idx;
    t_row              r_wb_row;

    // Seen flags, one per origin
    logic [CHANNELS-1:0] r_seen;
    logic [CHANNELS-1:0] n_seen;

    logic [31:0]       r_invalid;
    logic [31:0]       n_invalid;

    // Output register
    logic              r_out_vld;
    t_status           r_status;
    logic              r_phys_bad;
    logic [31:0]       r_gap;
    logic [31:0]       r_missing;
    logic [31:0]       r_reorder;

    logic              adv;
    logic              in_xfer;
    logic              wr_en;
    logic              s1_seen;
    t_row              s1_row;
    t_frame            in_frame;
    t_calc             calc;

    // Pipeline moves when the output register is free or being drained
    assign adv        = !r_out_vld || !i_out_stall;
    assign o_in_stall = !adv;
    assign in_xfer    = i_in_valid && adv;

    assign in_frame.phys_channel = i_phys_channel;
    assign in_frame.dlc          = i_dlc;
    assign in_frame.src_channel  = i_src_channel;
    assign in_frame.seq_number   = i_seq_number;
    assign in_frame.marker_bytes = i_marker_bytes;

    assign s1_idx  = r_s1_frame.src_channel[CH_W-1:0];
    assign s1_seen = r_seen[s1_idx];
    assign s1_row  = (r_wb_vld && (r_wb_idx == s1_idx)) ? r_wb_row : r_rd_row;

    pscg_calc u_calc (
        .i_frame (r_s1_frame),
        .i_row   (s1_row),
        .i_seen  (s1_seen),
        .o_calc  (calc)
    );

    assign wr_en = adv && r_s1_vld && calc.payload_ok;

    // Next seen flags and invalid count
    always_comb begin
        n_seen    = r_seen;
        n_invalid = r_invalid;
        if (wr_en) begin
            n_seen[s1_idx] = 1'b1;
        end
        if (r_s1_vld && !calc.payload_ok) begin
            n_invalid = r_invalid + 32'd1;
        end
    end

    // State memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[s1_idx] <= calc.row_new;
        end
        if (adv) begin
            r_rd_row <= mem[i_src_channel[CH_W-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_wb_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_seen    <= '0;
            r_invalid <= '0;
        end else if (adv) begin
            r_s1_vld  <= in_xfer;
            r_wb_vld  <= wr_en;
            r_out_vld <= r_s1_vld;
            r_seen    <= n_seen;
            r_invalid <= n_invalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_frame <= in_frame;
            r_wb_idx   <= s1_idx;
            r_wb_row   <= calc.row_new;
            r_status   <= calc.status;
            r_phys_bad <= ({1'b0, r_s1_frame.phys_channel} >= CHANNELS_9B);
            r_gap      <= calc.gap_size;
            r_missing  <= calc.missing_total;
            r_reorder  <= calc.reorder_total;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_status;
    assign o_phys_bad      = r_phys_bad;
    assign o_gap_size      = r_gap;
    assign o_missing_total = r_missing;
    assign o_reorder_total = r_reorder;
    assign o_invalid_total = r_invalid;

    // Invalid frames carry no per-origin figures
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_status == ST_INVALID) |->
        (r_gap == 32'd0 && r_missing == 32'd0 && r_reorder == 32'd0))
        else $error("invalid frame reports nonzero per-origin counts");

    // In-order and out-of-order frames add nothing missing; a gap always does
    a_gap_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_status == ST_INORDER || r_status == ST_REORDER)) |->
        (r_gap == 32'd0))
        else $error("gap size reported on an in-order or reordered frame");

    a_gap_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_status == ST_GAP) |-> (r_gap != 32'd0))
        else $error("gap status with zero gap size");

    // Seen flags only ever get set after reset
    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_seen & $past(r_seen)) == $past(r_seen)))
        else $error("seen flag cleared outside reset");

    // Forwarded write always targets a valid payload entry
    a_wb_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_vld |-> r_seen[r_wb_idx])
        else $error("forwarded row belongs to an unseen origin");

endmodule

### verif/per_channel_sequence_gap_checker_tb.sv
// Self-checking bench for per_channel_sequence_gap_checker: a directed frame table, then
// random frame streams; every result is predicted per origin and compared in order.
// Depends on pscg_pkg and the checker RTL.
`timescale 1ns / 1ps

module per_channel_sequence_gap_checker_tb
    import pscg_pkg::*;
();

    localparam int RANDOM_FRAMES  = 1750;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 8;

    // Expected content of one result transfer
    typedef struct packed {
        t_status     status;
        logic        phys_bad;
        logic [31:0] gap_size;
        logic [31:0] missing_total;
        logic [31:0] reorder_total;
        logic [31:0] invalid_total;
    } t_result;

    // Directed row: frame, plus a hand-written result where one is given
    typedef struct packed {
        t_frame  frame;
        logic    fixed;
        t_result res;
    } t_dir_row;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    localparam int DIR_ROWS = 23;

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_phys_channel   = '0;
    logic [3:0]  i_dlc            = '0;
    logic [7:0]  i_src_channel    = '0;
    logic [31:0] i_seq_number     = '0;
    logic [23:0] i_marker_bytes   = '0;
    logic        o_out_valid;
    logic        i_out_stall      = 1'b0;
    logic [2:0]  o_status;
    logic        o_phys_bad;
    logic [31:0] o_gap_size;
    logic [31:0] o_missing_total;
    logic [31:0] o_reorder_total;
    logic [31:0] o_invalid_total;

    logic        in_xfer;
    logic        out_xfer;

    // Sideband that travels with the frame on the input
    logic        frame_fixed = 1'b0;
    t_result     frame_res   = '0;

    // Tracker copy of the block state
    logic [31:0] trk_next    [CHANNELS];
    logic        trk_seen    [CHANNELS];
    logic [31:0] trk_missing [CHANNELS];
    logic [31:0] trk_reorder [CHANNELS];
    logic [31:0] trk_invalid = '0;

    t_result     pending_results[$];
    int          err_cnt    = 0;
    int          burst_left = 0;

    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;

    t_dir_row dir_tbl [DIR_ROWS] = '{
        // first frame with sequence zero
        '{'{8'd0,   4'd8,  8'd0, 32'd0, MARKER_VALID}, 1'b1,
          '{ST_FIRST,   1'b0, 32'd0, 32'd0, 32'd0, 32'd0}},
        '{'{8'd1,   4'd8,  8'd0, 32'd1, MARKER_VALID}, 1'b1,
          '{ST_INORDER, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0}},
        // gap on a bad physical channel
        '{'{8'd255, 4'd15, 8'd0, 32'd5, MARKER_VALID}, 1'b1,
          '{ST_GAP,     1'b1, 32'd3, 32'd3, 32'd0, 32'd0}},
        '{'{8'd3,   4'd8,  8'd0, 32'd2, MARKER_VALID}, 1'b1,
          '{ST_REORDER, 1'b0, 32'd0, 32'd3, 32'd1, 32'd0}},
        // invalid payloads: short dlc, bad markers, origin out of range
        '{'{8'd4,   4'd7,  8'd0, 32'd6, MARKER_VALID}, 1'b1,
          '{ST_INVALID, 1'b1, 32'd0, 32'd0, 32'd0, 32'd1}},
        '{'{8'd0,   4'd0,  8'd0, 32'd6, MARKER_VALID}, 1'b1,
          '{ST_INVALID, 1'b0, 32'd0, 32'd0, 32'd0, 32'd2}},
        '{'{8'd1,   4'd8,  8'd1, 32'd0, 24'h000000}, 1'b1,
          '{ST_INVALID, 1'b0, 32'd0, 32'd0, 32'd0, 32'd3}},
        '{'{8'd2,   4'd8,  8'd1, 32'd0, 24'hFFFFFF}, 1'b1,
          '{ST_INVALID, 1'b0, 32'd0, 32'd0, 32'd0, 32'd4}},
        '{'{8'd3,   4'd8,  8'd1, 32'd0, 24'hAA555B}, 1'b1,
          '{ST_INVALID, 1'b0, 32'd0, 32'd0, 32'd0, 32'd5}},
        '{'{8'd128, 4'd8,  8'd4, 32'd0, MARKER_VALID}, 1'b1,
          '{ST_INVALID, 1'b1, 32'd0, 32'd0, 32'd0, 32'd6}},
        '{'{8'd0,   4'd8,  8'd255, 32'd0, MARKER_VALID}, 1'b1,
          '{ST_INVALID, 1'b0, 32'd0, 32'd0, 32'd0, 32'd7}},
        // wraparound of the expected sequence
        '{'{8'd1,   4'd8,  8'd1, 32'hFFFF_FFFF, MARKER_VALID}, 1'b1,
          '{ST_FIRST,   1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd7}},
        '{'{8'd2,   4'd8,  8'd1, 32'd0, MARKER_VALID}, 1'b1,
          '{ST_INORDER, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd7}},
        '{'{8'd3,   4'd8,  8'd1, 32'hFFFF_FFFE, MARKER_VALID}, 1'b1,
          '{ST_GAP,     1'b0, 32'hFFFF_FFFD, 32'hFFFF_FFFC, 32'd0, 32'd7}},
        '{'{8'd4,   4'd8,  8'd1, 32'hFFFF_FFFF, MARKER_VALID}, 1'b1,
          '{ST_INORDER, 1'b1, 32'd0, 32'hFFFF_FFFC, 32'd0, 32'd7}},
        '{'{8'd0,   4'd8,  8'd2, 32'h1234_5678, MARKER_VALID}, 1'b1,
          '{ST_FIRST,   1'b0, 32'h1234_5678, 32'h1234_5678, 32'd0, 32'd7}},
        // remaining rows go through the tracker
        '{'{8'd2,   4'd15, 8'd3, 32'h8000_0000, MARKER_VALID}, 1'b0, '0},
        '{'{8'd3,   4'd9,  8'd3, 32'h7FFF_FFFF, MARKER_VALID}, 1'b0, '0},
        '{'{8'd1,   4'd12, 8'd2, 32'h1234_5679, MARKER_VALID}, 1'b0, '0},
        '{'{8'h7F,  4'd8,  8'd2, 32'h1234_5680, MARKER_VALID}, 1'b0, '0},
        '{'{8'd0,   4'd8,  8'h80, 32'd0, 24'h55AAA5}, 1'b0, '0},
        '{'{8'd2,   4'd8,  8'd3, 32'h8000_0001, MARKER_VALID}, 1'b0, '0},
        '{'{8'd3,   4'd8,  8'd0, 32'd6, MARKER_VALID}, 1'b0, '0}
    };

    per_channel_sequence_gap_checker i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_phys_channel   (i_phys_channel),
        .i_dlc            (i_dlc),
        .i_src_channel    (i_src_channel),
        .i_seq_number     (i_seq_number),
        .i_marker_bytes   (i_marker_bytes),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_phys_bad       (o_phys_bad),
        .o_gap_size       (o_gap_size),
        .o_missing_total  (o_missing_total),
        .o_reorder_total  (o_reorder_total),
        .o_invalid_total  (o_invalid_total)
    );

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Classify one frame against the tracked per-origin state
    function automatic t_result classify_frame(input t_frame f);
        t_result     r;
        int          org;
        logic [31:0] want;
        r = '0;
        r.phys_bad = (int'(f.phys_channel) >= CHANNELS);
        if (f.dlc >= MIN_DLC && f.marker_bytes == MARKER_VALID &&
            int'(f.src_channel) < CHANNELS) begin
            org  = int'(f.src_channel);
            want = trk_next[org];
            if (!trk_seen[org]) begin
                r.gap_size       = f.seq_number;
                trk_missing[org] = trk_missing[org] + f.seq_number;
                trk_seen[org]    = 1'b1;
                trk_next[org]    = f.seq_number + 32'd1;
                r.status         = ST_FIRST;
            end else if (f.seq_number == want) begin
                trk_next[org] = want + 32'd1;
                r.status      = ST_INORDER;
            end else if (f.seq_number > want) begin
                r.gap_size       = f.seq_number - want;
                trk_missing[org] = trk_missing[org] + r.gap_size;
                trk_next[org]    = f.seq_number + 32'd1;
                r.status         = ST_GAP;
            end else begin
                trk_reorder[org] = trk_reorder[org] + 32'd1;
                r.status         = ST_REORDER;
            end
            r.missing_total = trk_missing[org];
            r.reorder_total = trk_reorder[org];
        end else begin
            trk_invalid = trk_invalid + 32'd1;
            r.status    = ST_INVALID;
        end
        r.invalid_total = trk_invalid;
        return r;
    endfunction

    task automatic check_field(input string fld, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fld, want, got);
            err_cnt++;
        end
    endtask

    // Input transfers feed the tracker; output transfers are checked in order
    always @(posedge i_clk) begin : result_monitor
        t_frame  fr;
        t_result pred;
        t_result want;
        if (i_rst_n) begin
            if (in_xfer) begin
                fr   = '{i_phys_channel, i_dlc, i_src_channel, i_seq_number,
                         i_marker_bytes};
                pred = classify_frame(fr);
                pending_results.push_back(frame_fixed ? frame_res : pred);
            end
            if (out_xfer) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing pending, status %0d",
                             $time, o_status);
                    err_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("phys_bad", 32'(want.phys_bad), 32'(o_phys_bad));
                    check_field("gap_size", want.gap_size, o_gap_size);
                    check_field("missing_total", want.missing_total, o_missing_total);
                    check_field("reorder_total", want.reorder_total, o_reorder_total);
                    check_field("invalid_total", want.invalid_total, o_invalid_total);
                end
            end
        end
    end

    // Receiver stall pattern: stretches of no stall, light, heavy and toggling
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(4, 60);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 4) != 0);
            default:     i_out_stall <= ~i_out_stall;
        endcase
    end

    // Watchdog on cycles without any transfer
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || in_xfer || out_xfer)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // Present one frame and hold it until the transfer
    task automatic send_frame(input t_frame f, input logic fixed, input t_result res);
        i_in_valid     <= 1'b1;
        i_phys_channel <= f.phys_channel;
        i_dlc          <= f.dlc;
        i_src_channel  <= f.src_channel;
        i_seq_number   <= f.seq_number;
        i_marker_bytes <= f.marker_bytes;
        frame_fixed    <= fixed;
        frame_res      <= res;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Sender bursts: go idle once the current burst runs out, then start a new burst
    task automatic pace_sender();
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 20);
        end else begin
            burst_left--;
        end
    endtask

    // Hold off the sender until every pending result is out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        t_frame      f;
        int          pick;
        int          seq_pick;
        int          org;
        logic [31:0] gen_next [CHANNELS];
        logic        gen_seen [CHANNELS];

        for (int c = 0; c < CHANNELS; c++) begin
            trk_next[c]    = '0;
            trk_seen[c]    = 1'b0;
            trk_missing[c] = '0;
            trk_reorder[c] = '0;
            gen_next[c]    = '0;
            gen_seen[c]    = 1'b0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_frame(dir_tbl[r].frame, dir_tbl[r].fixed, dir_tbl[r].res);
            pace_sender();
        end
        drain_results();

        // Random streams: mostly well-formed per-origin sequences
        for (int n = 0; n < RANDOM_FRAMES; n++) begin
            if (n == RANDOM_FRAMES / 2)
                drain_results();

            pick = $urandom_range(0, 99);
            org  = $urandom_range(0, CHANNELS - 1);
            f.phys_channel = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'(org);
            f.dlc          = 4'($urandom_range(8, 15));
            f.src_channel  = 8'(org);
            f.marker_bytes = MARKER_VALID;

            seq_pick = $urandom_range(0, 99);
            if (seq_pick < 60)
                f.seq_number = gen_next[org];
            else if (seq_pick < 75)
                f.seq_number = gen_next[org] + 32'($urandom_range(1, 8));
            else if (seq_pick < 87)
                f.seq_number = gen_next[org] - 32'($urandom_range(1, 8));
            else if (seq_pick < 94)
                f.seq_number = $urandom;
            else
                f.seq_number = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));

            // broken payloads
            if (pick < 8)
                f.dlc = 4'($urandom_range(0, 7));
            else if (pick < 14)
                f.marker_bytes = MARKER_VALID ^ (24'd1 << $urandom_range(0, 23));
            else if (pick < 18)
                f.marker_bytes = 24'($urandom);
            else if (pick < 22)
                f.src_channel = 8'($urandom_range(CHANNELS, 255));
            else if (!gen_seen[org] || f.seq_number >= gen_next[org]) begin
                gen_next[org] = f.seq_number + 32'd1;
                gen_seen[org] = 1'b1;
            end

            send_frame(f, 1'b0, '0);
            pace_sender();
        end

        // Drain and finish
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
